// ----- design/sobm_pkg.sv -----
// Package for the shift-or byte matcher.
// Holds the request operation codes and the fixed match start field width.
// No dependencies.
`default_nettype none

package sobm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_RESTART = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  localparam int unsigned START_W = 32;

endpackage : sobm_pkg

`default_nettype wire

// ----- design/shift_or_byte_matcher.sv -----
// Top level of the shift-or (bitap) exact byte matcher.
// Depends on sobm_pkg for the operation codes and the result width.
// The whole datapath sits in this one module.
`default_nettype none

// The matcher takes one request per clock and returns exactly one result per
// request, in the cycle after it is accepted. A request is accepted whenever
// the result register is empty or its result is being taken in the same
// cycle, so with results taken, text bytes run at one byte per clock with no
// gaps. The pattern is held as up to MAX_PATTERN stored bytes, and each text
// byte is compared against all of them at once to form its mask word; that
// comparator row and the OR-and-shift of the match vector set the cycle time.
// Clearing the pattern and restarting the search each take a single request.
module shift_or_byte_matcher #(
  parameter int unsigned MAX_PATTERN = 31,
  parameter int unsigned INDEX_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire logic [1:0]                     operation,
  input  wire logic [7:0]                     byte_value,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic                                found,
  output logic [sobm_pkg::START_W-1:0]        match_start,
  output logic                                search_done,
  output logic                                pattern_full,
  output logic                                index_saturated
);

  localparam int unsigned VEC_W = MAX_PATTERN + 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SUB_W = (INDEX_BITS > sobm_pkg::START_W) ?
                                  INDEX_BITS : sobm_pkg::START_W;

  sobm_pkg::op_t op;

  logic [7:0]            pattern [MAX_PATTERN];
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      pattern_length_next;
  logic [VEC_W-1:0]      match_vector;
  logic [VEC_W-1:0]      match_vector_next;
  logic [INDEX_BITS-1:0] text_index;
  logic [INDEX_BITS-1:0] text_index_next;
  logic                  done_flag;
  logic                  done_flag_next;

  logic                  accept;
  logic                  append_ok;
  logic                  refused;
  logic                  hit;
  logic [VEC_W-1:0]      mask_word;
  logic [VEC_W-1:0]      shifted;
  logic [SUB_W-1:0]      start_wide;

  assign op        = sobm_pkg::op_t'(operation);
  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;
  assign append_ok = (pattern_length != LEN_W'(MAX_PATTERN));

  // Mask bit k is zero when pattern position k holds this byte.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      mask_word[k] = !((LEN_W'(k) < pattern_length) && (pattern[k] == byte_value));
    end
    mask_word[MAX_PATTERN] = 1'b1;
  end

  assign shifted    = {(match_vector[VEC_W-2:0] | mask_word[VEC_W-2:0]), 1'b0};
  assign start_wide = SUB_W'(text_index) - SUB_W'(pattern_length) + SUB_W'(1);

  always_comb begin
    pattern_length_next = pattern_length;
    match_vector_next   = match_vector;
    text_index_next     = text_index;
    done_flag_next      = done_flag;
    refused             = 1'b0;
    hit                 = 1'b0;
    unique case (op)
      sobm_pkg::OP_CLEAR: begin
        pattern_length_next = '0;
        match_vector_next   = {{(VEC_W-1){1'b1}}, 1'b0};
        text_index_next     = '0;
        done_flag_next      = 1'b0;
      end
      sobm_pkg::OP_APPEND: begin
        if (append_ok) begin
          pattern_length_next = pattern_length + LEN_W'(1);
        end else begin
          refused = 1'b1;
        end
      end
      sobm_pkg::OP_RESTART: begin
        match_vector_next = {{(VEC_W-1){1'b1}}, 1'b0};
        text_index_next   = '0;
        done_flag_next    = 1'b0;
      end
      sobm_pkg::OP_TEXT: begin
        if (!done_flag) begin
          match_vector_next = shifted;
          if ((pattern_length != '0) && !shifted[pattern_length]) begin
            hit            = 1'b1;
            done_flag_next = 1'b1;
          end
          if (text_index != {INDEX_BITS{1'b1}}) begin
            text_index_next = text_index + INDEX_BITS'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      match_vector   <= {{(VEC_W-1){1'b1}}, 1'b0};
      text_index     <= '0;
      done_flag      <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        pattern_length <= pattern_length_next;
        match_vector   <= match_vector_next;
        text_index     <= text_index_next;
        done_flag      <= done_flag_next;
        res_valid      <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (accept && (op == sobm_pkg::OP_APPEND) && (pattern_length == LEN_W'(k))) begin
        pattern[k] <= byte_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found           <= hit;
      match_start     <= hit ? start_wide[sobm_pkg::START_W-1:0] : '0;
      search_done     <= done_flag_next;
      pattern_full    <= refused;
      index_saturated <= (text_index_next == {INDEX_BITS{1'b1}});
    end
  end

  a_length_in_range: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond its maximum");

  a_vector_low_bit: assert property (@(posedge clk) disable iff (rst)
    !match_vector[0])
    else $error("match vector bit zero is set");

  a_found_sets_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && found) |-> (search_done && done_flag))
    else $error("match reported without the search being done");

  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == sobm_pkg::OP_CLEAR)) |=>
      ((pattern_length == '0) && !done_flag && (text_index == '0)))
    else $error("clear did not reset the search state");

  a_done_freezes: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == sobm_pkg::OP_TEXT) && done_flag) |=>
      (done_flag && $stable(text_index) && $stable(match_vector) && !found))
    else $error("text byte changed state after the search was done");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted request produced no result");

endmodule : shift_or_byte_matcher

`default_nettype wire

// ----- bench/tb_shift_or_byte_matcher.sv -----
// Self-checking testbench for the shift-or byte matcher.
// Depends on sobm_pkg for the operation codes; drives random request and result stalls.
// Each request's result is predicted in a scoreboard class and compared field by field.
`timescale 1ns / 100ps

module tb_shift_or_byte_matcher;

  localparam int unsigned MAX_PAT = 31;
  localparam int unsigned RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic        done;
    logic        full;
    logic        sat;
  } outcome_t;

  class search_tracker;
    logic [31:0] masks [256];
    logic [31:0] vector;
    int unsigned plen;
    logic [31:0] tindex;
    bit          done;
    outcome_t    outcome_q [$];
    int unsigned errors, requests, results, hits, refusals;

    function new();
      clear_pattern();
      restart();
    endfunction

    function void clear_pattern();
      foreach (masks[i]) masks[i] = '1;
      plen = 0;
    endfunction

    function void restart();
      vector = 32'hFFFF_FFFE;
      tindex = '0;
      done = 1'b0;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void note_request(sobm_pkg::op_t op, logic [7:0] b);
      outcome_t o;
      o = '0;
      requests++;
      case (op)
        sobm_pkg::OP_CLEAR: begin
          clear_pattern();
          restart();
        end
        sobm_pkg::OP_APPEND: begin
          if (plen >= MAX_PAT) begin
            o.full = 1'b1;
            refusals++;
          end else begin
            masks[b][plen] = 1'b0;
            plen++;
          end
        end
        sobm_pkg::OP_RESTART: restart();
        default: begin
          if (!done) begin
            vector = (vector | masks[b]) << 1;
            if (plen != 0 && !vector[plen]) begin
              o.found = 1'b1;
              o.start = tindex - plen + 1;
              done = 1'b1;
              hits++;
            end
            if (tindex != '1) tindex++;
          end
        end
      endcase
      o.done = done;
      o.sat = (tindex == '1);
      outcome_q.push_back(o);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s is %0h, expected %0h", results, field, got, want));
    endtask

    task check_result(logic f, logic [31:0] s, logic d, logic pf, logic sat);
      outcome_t o;
      results++;
      if (outcome_q.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        o = outcome_q.pop_front();
        compare("found", 32'(f), 32'(o.found));
        compare("match_start", s, o.start);
        compare("search_done", 32'(d), 32'(o.done));
        compare("pattern_full", 32'(pf), 32'(o.full));
        compare("index_saturated", 32'(sat), 32'(o.sat));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  operation;
  logic [7:0]  byte_value;
  logic        res_valid;
  logic        res_ready;
  logic        found;
  logic [sobm_pkg::START_W-1:0] match_start;
  logic        search_done;
  logic        pattern_full;
  logic        index_saturated;

  search_tracker sb;
  bit            idle_on;
  logic [7:0]    needle [$];

  shift_or_byte_matcher uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .operation(operation),
    .byte_value(byte_value),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .found(found),
    .match_start(match_start),
    .search_done(search_done),
    .pattern_full(pattern_full),
    .index_saturated(index_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    res_ready <= !(idle_on && $urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_result(found, match_start, search_done, pattern_full, index_saturated);
  end

  task automatic send_request(input sobm_pkg::op_t op, input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 19) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    byte_value <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(op, b);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 70) return 8'h61 + 8'($urandom_range(2));
    return 8'($urandom);
  endfunction

  task automatic load_pattern(input int unsigned len);
    logic [7:0] b;
    send_request(sobm_pkg::OP_CLEAR, 8'($urandom));
    needle.delete();
    repeat (len) begin
      b = pick_byte();
      if (needle.size() < MAX_PAT) needle.push_back(b);
      send_request(sobm_pkg::OP_APPEND, b);
    end
  endtask

  task automatic feed_text(input bit embed);
    int unsigned pre, post;
    logic [7:0]  b;
    pre = $urandom_range(15);
    post = $urandom_range(8);
    repeat (pre) send_request(sobm_pkg::OP_TEXT, pick_byte());
    if ($urandom_range(99) < 12) begin
      b = pick_byte();
      if (needle.size() < MAX_PAT) needle.push_back(b);
      send_request(sobm_pkg::OP_APPEND, b);
    end
    if (embed)
      foreach (needle[i]) send_request(sobm_pkg::OP_TEXT, needle[i]);
    repeat (post) send_request(sobm_pkg::OP_TEXT, pick_byte());
  endtask

  initial begin
    int unsigned kind, len;
    rst <= 1'b1;
    req_valid <= 1'b0;
    operation <= sobm_pkg::OP_CLEAR;
    byte_value <= 8'h00;
    res_ready <= 1'b0;
    idle_on = 1'b1;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // An empty pattern must never match.
    send_request(sobm_pkg::OP_TEXT, 8'h61);
    send_request(sobm_pkg::OP_TEXT, 8'hFF);
    send_request(sobm_pkg::OP_APPEND, 8'h00);
    send_request(sobm_pkg::OP_APPEND, 8'hFF);
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    send_request(sobm_pkg::OP_TEXT, 8'hFF);
    // Text after a match is ignored until the next restart.
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    send_request(sobm_pkg::OP_RESTART, 8'hA5);
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    send_request(sobm_pkg::OP_TEXT, 8'hFF);
    // A byte appended in the middle of a search extends the live pattern.
    send_request(sobm_pkg::OP_RESTART, 8'h5A);
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    send_request(sobm_pkg::OP_APPEND, 8'h11);
    send_request(sobm_pkg::OP_TEXT, 8'hFF);
    send_request(sobm_pkg::OP_TEXT, 8'h11);
    send_request(sobm_pkg::OP_CLEAR, 8'h5A);
    send_request(sobm_pkg::OP_TEXT, 8'h00);
    wait_drained();

    while (sb.requests < RANDOM_ITEMS + 18) begin
      idle_on = !(sb.requests >= 450 && sb.requests < 650);
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 6);
        load_pattern(len);
        feed_text($urandom_range(99) < 70);
        if ($urandom_range(99) < 40) begin
          send_request(sobm_pkg::OP_RESTART, 8'($urandom));
          feed_text($urandom_range(99) < 70);
        end
      end else if (kind < 75) begin
        if ($urandom_range(99) < 30) wait_drained();
        send_request(sobm_pkg::OP_RESTART, 8'($urandom));
        feed_text($urandom_range(99) < 60);
      end else if (kind < 82) begin
        load_pattern($urandom_range(MAX_PAT - 2, MAX_PAT + 2));
        feed_text(1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(sobm_pkg::op_t'($urandom_range(3)), 8'($urandom));
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Ran %0d requests with %0d results checked: %0d matches, %0d refused appends.",
             sb.requests, sb.results, sb.hits, sb.refusals);
    $display("Patterns of every length up to full, restarts and appends mid-search were exercised.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- shift_or_byte_matcher.f -----
design/sobm_pkg.sv
design/shift_or_byte_matcher.sv
bench/tb_shift_or_byte_matcher.sv
